// ----- design/ter_pkg.sv -----
// shared types, constants and helper functions for the triangle edge rasterizer
`default_nettype none

package ter_pkg;

   localparam int MAX_DIM   = 1024;
   localparam int FRAC_BITS = 4;

   localparam int COORD_W = 16;
   localparam int DELTA_W = COORD_W + 1;
   localparam int BOUND_W = 13;
   localparam int PIX_W   = 10;
   localparam int SIZE_W  = 11;
   localparam int IDX_W   = 20;
   localparam int COLOR_W = 32;
   localparam int EDGE_W  = 40;
   localparam int STEP_W  = 22;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_FB_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FB_HEIGHT = 1'd1;

   localparam logic KIND_SETUP = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   localparam logic [SIZE_W-1:0] FB_WIDTH_RESET  = 11'd640;
   localparam logic [SIZE_W-1:0] FB_HEIGHT_RESET = 11'd480;

   typedef struct packed {
      logic                      kind;
      logic [2:0][COORD_W-1:0]   vx;
      logic [2:0][COORD_W-1:0]   vy;
      logic [COLOR_W-1:0]        color;
   } req_type;

   typedef struct packed {
      logic                      kind;
      logic [2:0][COORD_W-1:0]   vx;
      logic [2:0][COORD_W-1:0]   vy;
      logic [COLOR_W-1:0]        color;
      logic [2:0][DELTA_W-1:0]   dx;
      logic [2:0][DELTA_W-1:0]   dy;
      logic [PIX_W-1:0]          min_x;
      logic [PIX_W-1:0]          min_y;
      logic [PIX_W-1:0]          max_x;
      logic [PIX_W-1:0]          max_y;
      logic                      empty;
      logic                      area_pos;
   } stage_type;

   typedef struct packed {
      logic [PIX_W-1:0]   pixel_x;
      logic [PIX_W-1:0]   pixel_y;
      logic [IDX_W-1:0]   pixel_index;
      logic [COLOR_W-1:0] write_color;
      logic               write_enable;
      logic               last;
   } rsp_type;

   // framebuffer size limited to the largest supported dimension
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r);
      return (r > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : r;
   endfunction

   // whole pixels, truncated toward zero
   function automatic logic signed [BOUND_W-1:0] to_pixel(input logic signed [COORD_W-1:0] v);
      logic signed [COORD_W:0] bias;
      logic signed [COORD_W:0] t;
      bias = v[COORD_W-1] ? (COORD_W+1)'((1 << FRAC_BITS) - 1) : '0;
      t    = (COORD_W+1)'(v) + bias;
      return BOUND_W'(t >>> FRAC_BITS);
   endfunction

   function automatic logic signed [COORD_W-1:0] min3(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b,
                                                      input logic signed [COORD_W-1:0] c);
      logic signed [COORD_W-1:0] m;
      m = a;
      if (b < m) m = b;
      if (c < m) m = c;
      return m;
   endfunction

   function automatic logic signed [COORD_W-1:0] max3(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b,
                                                      input logic signed [COORD_W-1:0] c);
      logic signed [COORD_W-1:0] m;
      m = a;
      if (b > m) m = b;
      if (c > m) m = c;
      return m;
   endfunction

endpackage

`default_nettype wire

// ----- design/triangle_edge_rasterizer.sv -----
// top level of the edge function triangle rasterizer
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  kind, three vertices (Q12.4), fill color
//   rsp      out        rsp_valid/rsp_stall  pixel x/y, index, color, write enable, last
//   csr      in         csr_wr_en            csr_index, csr_wdata (fb_width, fb_height)
//
// one transaction per cycle on both sides while no stall is raised; a request passes the
// input register, the setup stage and the edge stage with the result register, in order
// the edge stage holds the walk state and sets the rate: one update a cycle unless stalled
// reset is synchronous and needs no clearing pass; sizes return to 640 by 480
// rsp_stall holds the result register; the input register and the setup stage
// keep taking transactions until both are full, then req_stall rises
`default_nettype none

module triangle_edge_rasterizer
   import ter_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic                      req_kind,
   input  wire logic signed [COORD_W-1:0] req_v0_x,
   input  wire logic signed [COORD_W-1:0] req_v0_y,
   input  wire logic signed [COORD_W-1:0] req_v1_x,
   input  wire logic signed [COORD_W-1:0] req_v1_y,
   input  wire logic signed [COORD_W-1:0] req_v2_x,
   input  wire logic signed [COORD_W-1:0] req_v2_y,
   input  wire logic [COLOR_W-1:0]        req_fill_color,

   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [PIX_W-1:0]               rsp_pixel_x,
   output logic [PIX_W-1:0]               rsp_pixel_y,
   output logic [IDX_W-1:0]               rsp_pixel_index,
   output logic [COLOR_W-1:0]             rsp_write_color,
   output logic                           rsp_write_enable,
   output logic                           rsp_last,

   input  wire logic                      csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]      csr_index,
   input  wire logic [SIZE_W-1:0]         csr_wdata
);

   logic [SIZE_W-1:0] fb_width_ff, fb_width_in;
   logic [SIZE_W-1:0] fb_height_ff, fb_height_in;

   req_type   in_ff, req_item;
   logic      in_valid_ff, in_valid_in;
   logic      a_valid_ff, a_valid_in;
   logic      a_move, a_free, a_load, req_take;
   logic      b_ready;
   stage_type stage_ff;
   rsp_type   rsp_ff;

   assign a_move    = a_valid_ff && b_ready;
   assign a_free    = !a_valid_ff || a_move;
   assign a_load    = in_valid_ff && a_free;
   assign req_stall = in_valid_ff && !a_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      req_item.kind  = req_kind;
      req_item.vx    = {req_v2_x, req_v1_x, req_v0_x};
      req_item.vy    = {req_v2_y, req_v1_y, req_v0_y};
      req_item.color = req_fill_color;

      in_valid_in = in_valid_ff;
      if (!in_valid_ff || a_load) begin
         in_valid_in = req_valid;
      end

      a_valid_in = a_valid_ff && !a_move;
      if (a_load) begin
         a_valid_in = 1'b1;
      end

      fb_width_in  = fb_width_ff;
      fb_height_in = fb_height_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_FB_WIDTH: begin
               fb_width_in = csr_wdata;
            end
            CSR_FB_HEIGHT: begin
               fb_height_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         a_valid_ff   <= 1'b0;
         fb_width_ff  <= FB_WIDTH_RESET;
         fb_height_ff <= FB_HEIGHT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         a_valid_ff   <= a_valid_in;
         fb_width_ff  <= fb_width_in;
         fb_height_ff <= fb_height_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= req_item;
      end
   end

   ter_setup u_setup (
      .clock     (clock),
      .load      (a_load),
      .item      (in_ff),
      .fb_width  (fb_width_ff),
      .fb_height (fb_height_ff),
      .stage_ff  (stage_ff)
   );

   ter_walk u_walk (
      .clock        (clock),
      .reset        (reset),
      .stage        (stage_ff),
      .stage_valid  (a_valid_ff),
      .fb_width     (fb_width_ff),
      .rsp_stall    (rsp_stall),
      .ready        (b_ready),
      .rsp_valid_ff (rsp_valid),
      .rsp_ff       (rsp_ff)
   );

   assign rsp_pixel_x      = rsp_ff.pixel_x;
   assign rsp_pixel_y      = rsp_ff.pixel_y;
   assign rsp_pixel_index  = rsp_ff.pixel_index;
   assign rsp_write_color  = rsp_ff.write_color;
   assign rsp_write_enable = rsp_ff.write_enable;
   assign rsp_last         = rsp_ff.last;

   // a blocked setup stage keeps its transaction
   a_hold_check: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !b_ready |=> a_valid_ff)
      else $error("setup stage dropped a blocked transaction");

   // a blocked input register keeps its transaction unchanged
   in_hold_check: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !a_free |=> in_valid_ff && $stable(in_ff))
      else $error("input register lost a blocked transaction");

   // a taken request always lands in the input register
   take_check: assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_valid_ff)
      else $error("accepted request not captured");

   // the edge stage never advances over a stalled result
   rsp_block_check: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> !b_ready)
      else $error("edge stage advanced while the result was stalled");

endmodule

`default_nettype wire

// ----- design/ter_setup.sv -----
// setup stage: bounding box, clamping, edge deltas and area sign
`default_nettype none

module ter_setup
   import ter_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              load,
   input  wire req_type           item,
   input  wire logic [SIZE_W-1:0] fb_width,
   input  wire logic [SIZE_W-1:0] fb_height,
   output stage_type              stage_ff
);

   stage_type stage_in;

   logic signed [BOUND_W-1:0] lo_x, lo_y, hi_x, hi_y;
   logic signed [BOUND_W-1:0] clo_x, clo_y, chi_x, chi_y;
   logic signed [BOUND_W-1:0] w_s, h_s;
   logic signed [DELTA_W-1:0] e1x, e1y, e2x, e2y;
   logic signed [2*DELTA_W-1:0] p1, p2;
   logic signed [2*DELTA_W:0] area;
   logic [1:0] a, b;

   always_comb begin
      lo_x = to_pixel(min3($signed(item.vx[0]), $signed(item.vx[1]), $signed(item.vx[2])));
      lo_y = to_pixel(min3($signed(item.vy[0]), $signed(item.vy[1]), $signed(item.vy[2])));
      hi_x = to_pixel(max3($signed(item.vx[0]), $signed(item.vx[1]), $signed(item.vx[2])));
      hi_y = to_pixel(max3($signed(item.vy[0]), $signed(item.vy[1]), $signed(item.vy[2])));

      w_s = $signed({2'b00, eff_size(fb_width)});
      h_s = $signed({2'b00, eff_size(fb_height)});

      clo_x = (lo_x < 13'sd0) ? 13'sd0 : lo_x;
      clo_y = (lo_y < 13'sd0) ? 13'sd0 : lo_y;
      chi_x = (hi_x >= w_s) ? w_s - 13'sd1 : hi_x;
      chi_y = (hi_y >= h_s) ? h_s - 13'sd1 : hi_y;

      e1x  = DELTA_W'($signed(item.vx[2])) - DELTA_W'($signed(item.vx[0]));
      e1y  = DELTA_W'($signed(item.vy[1])) - DELTA_W'($signed(item.vy[0]));
      e2y  = DELTA_W'($signed(item.vy[2])) - DELTA_W'($signed(item.vy[0]));
      e2x  = DELTA_W'($signed(item.vx[1])) - DELTA_W'($signed(item.vx[0]));
      p1   = e1x * e1y;
      p2   = e2y * e2x;
      area = (2*DELTA_W+1)'(p1) - (2*DELTA_W+1)'(p2);

      stage_in.kind     = item.kind;
      stage_in.vx       = item.vx;
      stage_in.vy       = item.vy;
      stage_in.color    = item.color;
      stage_in.min_x    = clo_x[PIX_W-1:0];
      stage_in.min_y    = clo_y[PIX_W-1:0];
      stage_in.max_x    = chi_x[PIX_W-1:0];
      stage_in.max_y    = chi_y[PIX_W-1:0];
      stage_in.empty    = (clo_x > chi_x) || (clo_y > chi_y);
      stage_in.area_pos = !area[2*DELTA_W] && (area != '0);

      // edge k runs from vertex k+1 to vertex k+2
      for (int k = 0; k < 3; k++) begin
         a = (k == 2) ? 2'd0 : 2'(k + 1);
         b = (k == 0) ? 2'd2 : 2'(k - 1);
         stage_in.dx[k] = DELTA_W'($signed(item.vx[b])) - DELTA_W'($signed(item.vx[a]));
         stage_in.dy[k] = DELTA_W'($signed(item.vy[b])) - DELTA_W'($signed(item.vy[a]));
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/ter_walk.sv -----
// edge stage: initial edge values, raster walk state and result register
`default_nettype none

module ter_walk
   import ter_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire stage_type         stage,
   input  wire logic              stage_valid,
   input  wire logic [SIZE_W-1:0] fb_width,
   input  wire logic              rsp_stall,
   output logic                   ready,
   output logic                   rsp_valid_ff,
   output rsp_type                rsp_ff
);

   logic                     active_ff, active_in;
   logic                     area_pos_ff, area_pos_in;
   logic [PIX_W-1:0]         box_min_x_ff, box_min_x_in;
   logic [PIX_W-1:0]         box_max_x_ff, box_max_x_in;
   logic [PIX_W-1:0]         box_max_y_ff, box_max_y_in;
   logic [PIX_W-1:0]         cur_x_ff, cur_x_in;
   logic [PIX_W-1:0]         cur_y_ff, cur_y_in;
   logic [COLOR_W-1:0]       color_ff, color_in;
   logic signed [EDGE_W-1:0] row_edge_ff [3];
   logic signed [EDGE_W-1:0] row_edge_in [3];
   logic signed [EDGE_W-1:0] cur_edge_ff [3];
   logic signed [EDGE_W-1:0] cur_edge_in [3];
   logic signed [STEP_W-1:0] step_x_ff [3];
   logic signed [STEP_W-1:0] step_x_in [3];
   logic signed [STEP_W-1:0] step_y_ff [3];
   logic signed [STEP_W-1:0] step_y_in [3];
   logic                     rsp_valid_in;
   rsp_type                  rsp_in;

   logic signed [EDGE_W-1:0] init_edge [3];
   logic signed [STEP_W-1:0] init_sx [3];
   logic signed [STEP_W-1:0] init_sy [3];
   logic signed [COORD_W+1:0] px_s, py_s, ux, uy;
   logic signed [COORD_W+DELTA_W+1:0] prod_x, prod_y;
   logic [1:0] a;

   logic             fire, emit, covered, all_ge, all_le, row_end, last;
   logic [IDX_W:0]   idx_full;

   assign ready = !rsp_valid_ff || !rsp_stall;
   assign fire  = stage_valid && ready;

   // edge values at the first pixel centre, with one extra fraction bit
   always_comb begin
      px_s = $signed((COORD_W+2)'({stage.min_x, 1'b1}) << FRAC_BITS);
      py_s = $signed((COORD_W+2)'({stage.min_y, 1'b1}) << FRAC_BITS);
      for (int k = 0; k < 3; k++) begin
         a      = (k == 2) ? 2'd0 : 2'(k + 1);
         ux     = px_s - (COORD_W+2)'($signed({stage.vx[a], 1'b0}));
         uy     = py_s - (COORD_W+2)'($signed({stage.vy[a], 1'b0}));
         prod_x = ux * $signed(stage.dy[k]);
         prod_y = uy * $signed(stage.dx[k]);
         init_edge[k] = EDGE_W'(prod_x) - EDGE_W'(prod_y);
         init_sx[k]   = STEP_W'($signed(stage.dy[k])) <<< (FRAC_BITS + 1);
         init_sy[k]   = STEP_W'(0) - (STEP_W'($signed(stage.dx[k])) <<< (FRAC_BITS + 1));
      end
   end

   always_comb begin
      all_ge = 1'b1;
      all_le = 1'b1;
      for (int k = 0; k < 3; k++) begin
         all_ge = all_ge && !cur_edge_ff[k][EDGE_W-1];
         all_le = all_le && (cur_edge_ff[k][EDGE_W-1] || cur_edge_ff[k] == '0);
      end
      covered  = area_pos_ff ? all_ge : all_le;
      row_end  = cur_x_ff == box_max_x_ff;
      last     = row_end && (cur_y_ff == box_max_y_ff);
      idx_full = (IDX_W+1)'(cur_y_ff) * (IDX_W+1)'(eff_size(fb_width))
               + (IDX_W+1)'(cur_x_ff);
   end

   always_comb begin
      active_in    = active_ff;
      area_pos_in  = area_pos_ff;
      box_min_x_in = box_min_x_ff;
      box_max_x_in = box_max_x_ff;
      box_max_y_in = box_max_y_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      color_in     = color_ff;
      row_edge_in  = row_edge_ff;
      cur_edge_in  = cur_edge_ff;
      step_x_in    = step_x_ff;
      step_y_in    = step_y_ff;
      emit         = 1'b0;
      rsp_in       = '0;

      if (fire) begin
         if (stage.kind == KIND_SETUP) begin
            color_in    = stage.color;
            area_pos_in = stage.area_pos;
            if (stage.empty) begin
               // empty box: one closing transaction, nothing written
               active_in   = 1'b0;
               emit        = 1'b1;
               rsp_in.last = 1'b1;
            end else begin
               active_in    = 1'b1;
               box_min_x_in = stage.min_x;
               box_max_x_in = stage.max_x;
               box_max_y_in = stage.max_y;
               cur_x_in     = stage.min_x;
               cur_y_in     = stage.min_y;
               row_edge_in  = init_edge;
               cur_edge_in  = init_edge;
               step_x_in    = init_sx;
               step_y_in    = init_sy;
            end
         end else if (active_ff) begin
            emit               = 1'b1;
            rsp_in.pixel_x     = cur_x_ff;
            rsp_in.pixel_y     = cur_y_ff;
            rsp_in.pixel_index = idx_full[IDX_W-1:0];
            rsp_in.write_color = color_ff;
            rsp_in.write_enable = covered;
            rsp_in.last        = last;
            if (row_end) begin
               if (last) begin
                  active_in = 1'b0;
               end else begin
                  cur_y_in = cur_y_ff + 1'b1;
                  cur_x_in = box_min_x_ff;
                  for (int k = 0; k < 3; k++) begin
                     row_edge_in[k] = row_edge_ff[k] + EDGE_W'(step_y_ff[k]);
                     cur_edge_in[k] = row_edge_ff[k] + EDGE_W'(step_y_ff[k]);
                  end
               end
            end else begin
               cur_x_in = cur_x_ff + 1'b1;
               for (int k = 0; k < 3; k++) begin
                  cur_edge_in[k] = cur_edge_ff[k] + EDGE_W'(step_x_ff[k]);
               end
            end
         end
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (fire && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      area_pos_ff  <= area_pos_in;
      box_min_x_ff <= box_min_x_in;
      box_max_x_ff <= box_max_x_in;
      box_max_y_ff <= box_max_y_in;
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      color_ff     <= color_in;
      row_edge_ff  <= row_edge_in;
      cur_edge_ff  <= cur_edge_in;
      step_x_ff    <= step_x_in;
      step_y_ff    <= step_y_in;
      if (fire && emit) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire
